@@ rtl/lmfs_pkg.sv @@
package lmfs_pkg;

    // Panel geometry defaults
    localparam int LMFS_PANEL_WIDTH  = 72;
    localparam int LMFS_PANEL_HEIGHT = 64;
    localparam int LMFS_ROW_ROTATE   = 32;
    localparam int LMFS_DEPTH        = LMFS_PANEL_HEIGHT * ((LMFS_PANEL_WIDTH + 1) / 2);
    localparam int LMFS_ADDR_W       = $clog2(LMFS_DEPTH);

    // Request kinds
    localparam logic [2:0] KIND_SET    = 3'd0;
    localparam logic [2:0] KIND_OR     = 3'd1;
    localparam logic [2:0] KIND_INVERT = 3'd2;
    localparam logic [2:0] KIND_READ   = 3'd3;
    localparam logic [2:0] KIND_SCAN   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;

    // Stream framing bytes
    localparam logic [7:0] BYTE_START = 8'h23;
    localparam logic [7:0] BYTE_B42   = 8'h42;
    localparam logic [7:0] BYTE_ESC   = 8'h65;
    localparam logic [7:0] BYTE_B66   = 8'h66;

    // Escape codes following BYTE_ESC
    localparam logic [2:0] ESC_NONE  = 3'd0;
    localparam logic [2:0] ESC_START = 3'd1;
    localparam logic [2:0] ESC_B42   = 3'd2;
    localparam logic [2:0] ESC_ESC   = 3'd3;
    localparam logic [2:0] ESC_B66   = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] col;
        logic [7:0] row;
        logic [3:0] level;
    } t_lmfs_in;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [3:0] level_out;
        logic       read_ok;
        logic       frame_end;
        logic       last;
    } t_lmfs_out;

    // Zero maps to full scale, anything else to 16 - v
    function automatic logic [3:0] lmfs_invert(input logic [3:0] v);
        logic [4:0] diff;
        diff = 5'd16 - {1'b0, v};
        return (v == 4'd0) ? 4'd15 : diff[3:0];
    endfunction

    function automatic logic [2:0] lmfs_esc_code(input logic [7:0] b);
        logic [2:0] code;
        code = ESC_NONE;
        if (b == BYTE_START) code = ESC_START;
        else if (b == BYTE_B42) code = ESC_B42;
        else if (b == BYTE_ESC) code = ESC_ESC;
        else if (b == BYTE_B66) code = ESC_B66;
        return code;
    endfunction

endpackage

@@ rtl/lmfs_store.sv @@
module lmfs_store #(
    parameter int DEPTH  = lmfs_pkg::LMFS_DEPTH,
    parameter int ADDR_W = lmfs_pkg::LMFS_ADDR_W
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [3:0]        o_rd_even,
    output logic [3:0]        o_rd_odd,
    input  logic              i_wr_even,
    input  logic              i_wr_odd,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [3:0]        i_wr_data
);
    import lmfs_pkg::*;

    // One bank per column parity so a pixel pair reads in one access
    logic [3:0] mem_even [DEPTH];
    logic [3:0] mem_odd  [DEPTH];
    logic [3:0] r_rd_even;
    logic [3:0] r_rd_odd;

    always_ff @(posedge i_clk) begin
        if (i_wr_even) begin
            mem_even[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_even <= mem_even[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_odd) begin
            mem_odd[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_odd <= mem_odd[i_rd_addr];
        end
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;

endmodule

@@ rtl/led_matrix_framebuffer_stuffed_scanout_core.sv @@
// Steps: a read or scan request is accepted, reads the store, and then builds its results
// for the output; set, OR and invert take accept, memory read and write back per request.
// Throughput: one request at a time; a scan request delivers 1 to 3 bytes, one per cycle
// unless i_out_stall holds them. Clear sweeps one pixel pair per cycle over PANEL_HEIGHT *
// ceil(PANEL_WIDTH/2) store entries (2304 at the default 72x64 panel), using the write port.
// Reset (i_rst_n low, synchronous) zeroes the scan position and starts the same sweep.
module led_matrix_framebuffer_stuffed_scanout_core #(
    parameter int PANEL_WIDTH  = lmfs_pkg::LMFS_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = lmfs_pkg::LMFS_PANEL_HEIGHT,
    parameter int ROW_ROTATE   = lmfs_pkg::LMFS_ROW_ROTATE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lmfs_pkg::t_lmfs_in  i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lmfs_pkg::t_lmfs_out o_out_res
);
    import lmfs_pkg::*;

    // Store layout: entry row * PAIRS_ST + pair; an odd width leaves its last
    // column in the even bank, where it is written and read but never scanned.
    localparam int PAIRS_ST   = (PANEL_WIDTH + 1) / 2;
    localparam int SCAN_PAIRS = PANEL_WIDTH / 2;
    localparam int DEPTH      = PANEL_HEIGHT * PAIRS_ST;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int ROW_W      = $clog2(PANEL_HEIGHT);
    localparam int PAIR_W     = (PAIRS_ST > 1) ? $clog2(PAIRS_ST) : 1;
    localparam int ROT_MOD    = ROW_ROTATE % PANEL_HEIGHT;

    // Sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;
    localparam logic [2:0] S_CLEAR = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [ROW_W-1:0]  r_line, n_line;
    logic [PAIR_W-1:0] r_pair, n_pair;

    // Request held while it works through the store
    logic [2:0]        r_kind, n_kind;
    logic [3:0]        r_level, n_level;
    logic              r_odd, n_odd;
    logic              r_inside, n_inside;
    logic              r_start, n_start;
    logic              r_fe, n_fe;
    logic [ADDR_W-1:0] r_addr, n_addr;

    // Result list of the current request
    t_lmfs_out         r_res [3];
    t_lmfs_out         n_res [3];
    logic [1:0]        r_cnt, n_cnt;
    logic [1:0]        r_idx, n_idx;

    logic              accept;
    logic              in_panel;
    logic [ROW_W-1:0]  req_row;
    logic [PAIR_W-1:0] req_pair;
    logic [ROW_W:0]    rot_sum;
    logic [ROW_W-1:0]  rot_row;
    logic              line_first, line_last, pair_first, pair_last;

    logic [3:0]        rd_even, rd_odd, old_lv, new_lv;
    logic              wr_even, wr_odd;
    logic [ADDR_W-1:0] wr_addr;
    logic [3:0]        wr_data;
    logic [7:0]        pix;
    logic [2:0]        code;
    logic [1:0]        k;

    lmfs_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (r_addr),
        .o_rd_even (rd_even),
        .o_rd_odd  (rd_odd),
        .i_wr_even (wr_even),
        .i_wr_odd  (wr_odd),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_res   = r_res[r_idx];

    // Coordinate check and store address of a pixel request
    assign in_panel = (i_in_req.col < 8'(PANEL_WIDTH)) && (i_in_req.row < 8'(PANEL_HEIGHT));
    assign req_row  = i_in_req.row[ROW_W-1:0];
    assign req_pair = i_in_req.col[PAIR_W:1];

    // Output line L shows stored row (L + rotate) mod height; sum stays below 2*height
    assign rot_sum = {1'b0, r_line} + (ROW_W+1)'(ROT_MOD);
    assign rot_row = (rot_sum >= (ROW_W+1)'(PANEL_HEIGHT))
                   ? ROW_W'(rot_sum - (ROW_W+1)'(PANEL_HEIGHT)) : rot_sum[ROW_W-1:0];

    assign line_first = (r_line == '0);
    assign line_last  = (r_line == ROW_W'(PANEL_HEIGHT - 1));
    assign pair_first = (r_pair == '0);
    assign pair_last  = (r_pair == PAIR_W'(SCAN_PAIRS - 1));

    // Modify step on the pixel read back
    assign old_lv = r_odd ? rd_odd : rd_even;
    always_comb begin
        unique case (r_kind)
            KIND_SET:    new_lv = r_level;
            KIND_OR:     new_lv = old_lv | r_level;
            KIND_INVERT: new_lv = lmfs_invert(old_lv);
            default:     new_lv = old_lv;
        endcase
    end

    assign pix  = {rd_odd, rd_even};
    assign code = lmfs_esc_code(pix);

    // Write port: sweep zeroes both banks, otherwise write back one pixel
    always_comb begin
        wr_addr = r_addr;
        wr_data = new_lv;
        wr_even = 1'b0;
        wr_odd  = 1'b0;
        if (r_state == S_INIT || r_state == S_CLEAR) begin
            wr_addr = r_sweep;
            wr_data = 4'd0;
            wr_even = 1'b1;
            wr_odd  = 1'b1;
        end else if (r_state == S_EXEC && r_inside &&
                     (r_kind == KIND_SET || r_kind == KIND_OR || r_kind == KIND_INVERT)) begin
            wr_even = !r_odd;
            wr_odd  = r_odd;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_sweep  = r_sweep;
        n_line   = r_line;
        n_pair   = r_pair;
        n_kind   = r_kind;
        n_level  = r_level;
        n_odd    = r_odd;
        n_inside = r_inside;
        n_start  = r_start;
        n_fe     = r_fe;
        n_addr   = r_addr;
        n_res    = r_res;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        k        = 2'd0;

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                n_sweep = ADDR_W'(r_sweep + 1'b1);
                if (r_sweep == ADDR_W'(DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_in_req.kind;
                    n_level  = i_in_req.level;
                    n_odd    = i_in_req.col[0];
                    n_inside = in_panel;
                    n_addr   = ADDR_W'(ADDR_W'(req_row) * ADDR_W'(PAIRS_ST) + ADDR_W'(req_pair));
                    n_state  = S_READ;
                    if (i_in_req.kind == KIND_SCAN) begin
                        // Latch the pair position, then advance the scan
                        n_addr  = ADDR_W'(ADDR_W'(rot_row) * ADDR_W'(PAIRS_ST)
                                          + ADDR_W'(r_pair));
                        n_odd   = 1'b0;
                        n_start = line_first && pair_first;
                        n_fe    = line_last && pair_last;
                        if (pair_last) begin
                            n_pair = '0;
                            n_line = line_last ? '0 : ROW_W'(r_line + 1'b1);
                        end else begin
                            n_pair = PAIR_W'(r_pair + 1'b1);
                        end
                    end else if (i_in_req.kind == KIND_CLEAR) begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_idx   = 2'd0;
                n_state = S_IDLE;
                if (r_kind == KIND_READ) begin
                    n_res[0] = '{byte_out: 8'd0, level_out: r_inside ? old_lv : 4'd0,
                                 read_ok: r_inside, frame_end: 1'b0, last: 1'b1};
                    n_cnt    = 2'd1;
                    n_state  = S_EMIT;
                end else if (r_kind == KIND_SCAN) begin
                    if (r_start) begin
                        n_res[0] = '{byte_out: BYTE_START, level_out: 4'd0, read_ok: 1'b0,
                                     frame_end: 1'b0, last: 1'b0};
                        k = 2'd1;
                    end
                    if (code != ESC_NONE) begin
                        n_res[k] = '{byte_out: BYTE_ESC, level_out: 4'd0, read_ok: 1'b0,
                                     frame_end: r_fe, last: 1'b0};
                        n_res[2'(k + 2'd1)] = '{byte_out: {5'd0, code}, level_out: 4'd0,
                                                read_ok: 1'b0, frame_end: r_fe, last: 1'b1};
                        n_cnt = 2'(k + 2'd2);
                    end else begin
                        n_res[k] = '{byte_out: pix, level_out: 4'd0, read_ok: 1'b0,
                                     frame_end: r_fe, last: 1'b1};
                        n_cnt = 2'(k + 2'd1);
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Advance on each taken result, drop back to idle after the last
                if (!i_out_stall) begin
                    if (r_idx == 2'(r_cnt - 2'd1)) begin
                        n_idx   = 2'd0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx = 2'(r_idx + 2'd1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_sweep <= '0;
            r_line  <= '0;
            r_pair  <= '0;
            r_cnt   <= 2'd0;
            r_idx   <= 2'd0;
        end else begin
            r_state <= n_state;
            r_sweep <= n_sweep;
            r_line  <= n_line;
            r_pair  <= n_pair;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_level  <= n_level;
        r_odd    <= n_odd;
        r_inside <= n_inside;
        r_start  <= n_start;
        r_fe     <= n_fe;
        r_addr   <= n_addr;
        r_res    <= n_res;
    end

endmodule

@@ rtl/lmfs_checker.sv @@
module lmfs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input lmfs_pkg::t_lmfs_out o_out_res
);
    import lmfs_pkg::*;

    // Reset starts the store sweep, so no request is taken right after it
    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request stall low after reset");

    // A taken request blocks the input until it is done
    a_accept_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second request taken back to back");

    // No request is taken while results are still pending
    a_emit_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while results pending");

    // A read result carries no stream byte and closes its request
    a_read_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_res.read_ok) |->
            (o_out_res.byte_out == 8'd0 && o_out_res.last && !o_out_res.frame_end))
        else $error("malformed read result");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(o_out_valid && i_out_stall)) |->
            (o_out_valid && $stable(o_out_res)))
        else $error("stalled result changed");

endmodule

bind led_matrix_framebuffer_stuffed_scanout_core lmfs_checker u_lmfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_res   (o_out_res)
);

@@ tb/tb_led_matrix_framebuffer_stuffed_scanout_core.sv @@
module tb_led_matrix_framebuffer_stuffed_scanout_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lmfs_pkg::*;

    localparam int PANEL_W   = LMFS_PANEL_WIDTH;
    localparam int PANEL_H   = LMFS_PANEL_HEIGHT;
    localparam int ROT       = LMFS_ROW_ROTATE;
    localparam int PAIRS     = PANEL_W / 2;
    localparam int DRAIN_CYC = 20;

    // Request kinds the block must ignore
    localparam logic [2:0] KIND_SPARE_LO = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------
    // Frame store predictor plus the queue of bytes and read-backs it owes
    // ------------------------------------------------------------------
    class framebuffer_scoreboard;
        logic [3:0]  pixel_level [PANEL_H][PANEL_W];
        int unsigned line_idx;
        int unsigned pair_idx;
        t_lmfs_out   owed_q [$];
        int unsigned mismatches;

        function new();
            wipe_store();
            line_idx   = 0;
            pair_idx   = 0;
            mismatches = 0;
        endfunction

        function void wipe_store();
            foreach (pixel_level[r, c]) pixel_level[r][c] = 4'd0;
        endfunction

        function void owe(logic [7:0] b, logic [3:0] lv, logic ok, logic fe, logic la);
            t_lmfs_out res;
            res.byte_out  = b;
            res.level_out = lv;
            res.read_ok   = ok;
            res.frame_end = fe;
            res.last      = la;
            owed_q.push_back(res);
        endfunction

        // Emit the optional start byte, then the pair byte or its escape
        function void scan_pair_out();
            int unsigned src_row;
            logic [7:0]  pix;
            logic [2:0]  code;
            logic        fe;
            src_row = (line_idx + ROT) % PANEL_H;
            pix     = {pixel_level[src_row][2*pair_idx+1], pixel_level[src_row][2*pair_idx]};
            fe      = (line_idx == PANEL_H - 1) && (pair_idx == PAIRS - 1);
            if (line_idx == 0 && pair_idx == 0) begin
                owe(BYTE_START, 4'd0, 1'b0, 1'b0, 1'b0);
            end
            case (pix)
                BYTE_START: code = ESC_START;
                BYTE_B42:   code = ESC_B42;
                BYTE_ESC:   code = ESC_ESC;
                BYTE_B66:   code = ESC_B66;
                default:    code = ESC_NONE;
            endcase
            if (code != ESC_NONE) begin
                owe(BYTE_ESC, 4'd0, 1'b0, fe, 1'b0);
                owe({5'd0, code}, 4'd0, 1'b0, fe, 1'b1);
            end else begin
                owe(pix, 4'd0, 1'b0, fe, 1'b1);
            end
            // Advance to the next pair, wrapping line and frame
            pair_idx++;
            if (pair_idx >= PAIRS) begin
                pair_idx = 0;
                line_idx = (line_idx + 1 >= PANEL_H) ? 0 : line_idx + 1;
            end
        endfunction

        function void note_request(t_lmfs_in req);
            logic       in_panel;
            logic [3:0] cur;
            in_panel = (req.col < PANEL_W) && (req.row < PANEL_H);
            cur      = in_panel ? pixel_level[req.row][req.col] : 4'd0;
            case (req.kind)
                KIND_SET: begin
                    if (in_panel) pixel_level[req.row][req.col] = req.level;
                end
                KIND_OR: begin
                    if (in_panel) pixel_level[req.row][req.col] = cur | req.level;
                end
                KIND_INVERT: begin
                    // zero goes to full scale; otherwise 16 - v, which is -v in 4 bits
                    if (in_panel) pixel_level[req.row][req.col] = (cur == 4'd0) ? 4'd15 : 4'd0 - cur;
                end
                KIND_READ:  owe(8'd0, cur, in_panel, 1'b0, 1'b1);
                KIND_SCAN:  scan_pair_out();
                KIND_CLEAR: wipe_store();
                default: ;
            endcase
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
            mismatches++;
        endfunction

        function void check_result(t_lmfs_out got);
            t_lmfs_out want;
            if (owed_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none actual 0x%0h",
                         $time, got);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            if (got.byte_out  !== want.byte_out)  report("byte_out",  want.byte_out,  got.byte_out);
            if (got.level_out !== want.level_out) report("level_out", want.level_out, got.level_out);
            if (got.read_ok   !== want.read_ok)   report("read_ok",   want.read_ok,   got.read_ok);
            if (got.frame_end !== want.frame_end) report("frame_end", want.frame_end, got.frame_end);
            if (got.last      !== want.last)      report("last",      want.last,      got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT and shared state
    // ------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_lmfs_in  i_in_req;
    logic      o_out_valid;
    logic      i_out_stall;
    t_lmfs_out o_out_res;

    framebuffer_scoreboard sb;
    logic calm;  // hold both sides free of idling while set

    always #5 i_clk = ~i_clk;

    led_matrix_framebuffer_stuffed_scanout_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res)
    );

    // Stall the result side at random, 9 percent of the time, unless calm
    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 9);
    end

    // Check every result taken on a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_out_res);
        end
    end

    // Present one request, idling at random first, and hold it until taken
    task automatic send_request(input t_lmfs_in req);
        while (!calm && $urandom_range(0, 99) < 9) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic issue(input logic [2:0] k, input logic [7:0] c, input logic [7:0] r,
                         input logic [3:0] lv);
        t_lmfs_in req;
        req.kind  = k;
        req.col   = c;
        req.row   = r;
        req.level = lv;
        send_request(req);
    endtask

    // Pick coordinates and a level: aim at the pair about to be scanned with
    // nibbles that build framing bytes, or anywhere on the panel, or anywhere
    // in the full 8-bit range
    task automatic pick_target(output logic [7:0] c, output logic [7:0] r,
                               output logic [3:0] lv);
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            r  = 8'((sb.line_idx + ROT) % PANEL_H);
            c  = 8'((2 * sb.pair_idx + $urandom_range(0, 7)) % PANEL_W);
            lv = 4'($urandom_range(2, 6));
        end else if (sel < 75) begin
            c  = 8'($urandom_range(0, PANEL_W - 1));
            r  = 8'($urandom_range(0, PANEL_H - 1));
            lv = 4'($urandom_range(0, 15));
        end else begin
            c  = 8'($urandom_range(0, 255));
            r  = 8'($urandom_range(0, 255));
            lv = 4'($urandom_range(0, 15));
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned pick;
        logic [2:0]  k;
        logic [7:0]  c;
        logic [7:0]  r;
        logic [3:0]  lv;

        sb          = new();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Field extremes and range edges
        issue(KIND_SET,    8'd0,   8'd0,   4'd15);
        issue(KIND_READ,   8'd0,   8'd0,   4'd0);
        issue(KIND_SET,    8'd71,  8'd63,  4'd9);
        issue(KIND_READ,   8'd71,  8'd63,  4'd0);
        issue(KIND_SET,    8'd72,  8'd63,  4'd7);   // column just past the edge: drop
        issue(KIND_SET,    8'd255, 8'd255, 4'd15);
        issue(KIND_READ,   8'd72,  8'd0,   4'd0);
        issue(KIND_READ,   8'd0,   8'd64,  4'd0);
        issue(KIND_READ,   8'd255, 8'd255, 4'd15);
        // OR merges, invert maps zero to full scale and v to 16 - v
        issue(KIND_SET,    8'd1,   8'd0,   4'd5);
        issue(KIND_OR,     8'd1,   8'd0,   4'd10);
        issue(KIND_READ,   8'd1,   8'd0,   4'd0);
        issue(KIND_INVERT, 8'd2,   8'd0,   4'd0);
        issue(KIND_INVERT, 8'd2,   8'd0,   4'd0);
        issue(KIND_READ,   8'd2,   8'd0,   4'd0);
        issue(KIND_INVERT, 8'd200, 8'd200, 4'd0);
        issue(KIND_SPARE_LO, 8'd0, 8'd0,   4'd3);
        issue(KIND_SPARE_HI, 8'd0, 8'd0,   4'd3);
        // Build all four framing bytes on the first scanned line (row 32),
        // and 0x66 on the final pair of the frame (row 31, columns 70 and 71)
        for (int i = 0; i < 8; i++) begin
            issue(KIND_SET, 8'(i), 8'(ROT), (i == 0) ? 4'd3 : (i == 1) ? 4'd2 :
                  (i == 2) ? 4'd2 : (i == 3) ? 4'd4 : (i == 4) ? 4'd5 : 4'd6);
        end
        issue(KIND_SET, 8'd70, 8'((ROT + PANEL_H - 1) % PANEL_H), 4'd6);
        issue(KIND_SET, 8'd71, 8'((ROT + PANEL_H - 1) % PANEL_H), 4'd6);
        for (int i = 0; i < 5; i++) issue(KIND_SCAN, 8'd0, 8'd0, 4'd0);
        issue(KIND_CLEAR, 8'd0, 8'd0, 4'd0);
        issue(KIND_READ,  8'd0, 8'(ROT), 4'd0);

        // Random mix; the middle third runs with no idling on either side
        for (int n = 0; n < 420; n++) begin
            calm = (n >= 140 && n < 280);
            pick = $urandom_range(0, 99);
            if (pick < 25)      k = KIND_SET;
            else if (pick < 37) k = KIND_OR;
            else if (pick < 47) k = KIND_INVERT;
            else if (pick < 67) k = KIND_READ;
            else if (pick < 95) k = KIND_SCAN;
            else if (pick < 96) k = KIND_CLEAR;
            else if (pick < 98) k = KIND_SPARE_LO;
            else                k = KIND_SPARE_HI;
            pick_target(c, r, lv);
            issue(k, c, r, lv);
        end
        calm = 1'b0;

        @(negedge i_clk) i_in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run, clear sweeps included
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
rtl/lmfs_pkg.sv
rtl/lmfs_store.sv
rtl/led_matrix_framebuffer_stuffed_scanout_core.sv
rtl/lmfs_checker.sv
tb/tb_led_matrix_framebuffer_stuffed_scanout_core.sv
